>>> rtl/nncs_pkg.sv
// ----------------------------------------------------------------------------
// nncs_pkg
// Shared constants, codes and types of the nearest neighbor channel sampler.
// ----------------------------------------------------------------------------
package nncs_pkg;

  // Image geometry limits.
  localparam int MAX_SOURCE_SIDE = 64;
  localparam int MAX_TARGET_SIDE = 4096;
  localparam int PIX_DEPTH       = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;

  // Field and datapath widths.
  localparam int SIDE_W    = 7;
  localparam int TGT_W     = 13;
  localparam int COORD_W   = 12;
  localparam int ADDR_W    = 12;
  localparam int PIX_W     = 32;
  localparam int CHAN_W    = 2;
  localparam int MASK_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  // The mapped coordinate is always below the source side, so six bits do.
  localparam int QUOT_W     = $clog2(MAX_SOURCE_SIDE);
  localparam int STEP_W     = $clog2(QUOT_W);
  localparam int PROD_W     = COORD_W + SIDE_W;
  localparam int IDX_FULL_W = QUOT_W + SIDE_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIDE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_CHANNEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_CHANNEL   = 2'd3;

  // Request kinds carried in tuser.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Start of a coordinate mapping.
  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [SIDE_W-1:0]  side;
    logic [TGT_W-1:0]   target;
  } map_req_t;

  // Finished coordinate mapping.
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] sx;
    logic [QUOT_W-1:0] sy;
  } map_rsp_t;

endpackage

>>> rtl/nncs_pixel_ram.sv
// ----------------------------------------------------------------------------
// nncs_pixel_ram
// Source pixel memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nncs_pixel_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [nncs_pkg::ADDR_W-1:0] wr_addr,
  input  logic [nncs_pkg::PIX_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [nncs_pkg::ADDR_W-1:0] rd_addr,
  output logic [nncs_pkg::PIX_W-1:0]  rd_data
);

  logic [nncs_pkg::PIX_W-1:0] mem [nncs_pkg::PIX_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/nncs_coord_map.sv
// ----------------------------------------------------------------------------
// nncs_coord_map
// Maps a target coordinate pair to source coordinates by nearest neighbor,
// using a restoring divider that retires one quotient bit per cycle per axis.
// ----------------------------------------------------------------------------
module nncs_coord_map (
  input  logic                clk,
  input  logic                rst,
  input  nncs_pkg::map_req_t  req,
  output nncs_pkg::map_rsp_t  rsp
);

  localparam int DIV_SHIFT = nncs_pkg::QUOT_W - 1;

  logic                              busy;
  logic                              done;
  logic [nncs_pkg::STEP_W-1:0]       step;
  logic [nncs_pkg::PROD_W-1:0]       rem_x;
  logic [nncs_pkg::PROD_W-1:0]       rem_y;
  logic [nncs_pkg::PROD_W-1:0]       div;
  logic [nncs_pkg::QUOT_W-1:0]       q_x;
  logic [nncs_pkg::QUOT_W-1:0]       q_y;
  logic                              sat_x;
  logic                              sat_y;
  logic [nncs_pkg::QUOT_W-1:0]       side_m1;

  // Control: busy while the quotient bits are retired, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == '0);
      if (req.start) begin
        busy <= 1'b1;
        step <= nncs_pkg::STEP_W'(DIV_SHIFT);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath. A coordinate at or beyond the target side saturates to side-1;
  // otherwise the quotient is below the side and fits the quotient width.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_x   <= nncs_pkg::PROD_W'(req.coord_x) * nncs_pkg::PROD_W'(req.side);
      rem_y   <= nncs_pkg::PROD_W'(req.coord_y) * nncs_pkg::PROD_W'(req.side);
      div     <= nncs_pkg::PROD_W'(req.target) << DIV_SHIFT;
      q_x     <= '0;
      q_y     <= '0;
      sat_x   <= {1'b0, req.coord_x} >= req.target;
      sat_y   <= {1'b0, req.coord_y} >= req.target;
      side_m1 <= nncs_pkg::QUOT_W'(req.side - 1'b1);
    end else if (busy) begin
      if (rem_x >= div) begin
        rem_x <= rem_x - div;
        q_x   <= {q_x[nncs_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        q_x   <= {q_x[nncs_pkg::QUOT_W-2:0], 1'b0};
      end
      if (rem_y >= div) begin
        rem_y <= rem_y - div;
        q_y   <= {q_y[nncs_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        q_y   <= {q_y[nncs_pkg::QUOT_W-2:0], 1'b0};
      end
      div <= div >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.sx   = sat_x ? side_m1 : q_x;
  assign rsp.sy   = sat_y ? side_m1 : q_y;

endmodule

>>> rtl/nearest_neighbor_channel_sampler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_channel_sampler
// Stores a square RGBA source image and answers sample requests with one
// nearest neighbor source channel routed to a chosen destination channel.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                      Payload
//  s_axis    s_axis_tvalid / s_axis_tready  tuser opcode, tdata pixel fields
//  m_axis    m_axis_tvalid / m_axis_tready  tdata sample_rgba, authored_mask
//  cfg       cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A write request leaves the sequencer idle and gives no result.
// A sample request passes the map, read and result states, the map state
// waiting on the bit-per-cycle divider; the next request is taken once the
// result is in the output register (a source side of zero skips map and read).
// One request is in flight at a time; a result waiting in the output
// register does not block acceptance, only the next result.
// Reset clears control and configuration; pixel memory is not cleared.
//
module nearest_neighbor_channel_sampler (
  input  logic                           clk,
  input  logic                           rst,
  // Fields from bit 0: pixel_index[11:0], pixel_rgba[43:12],
  // coord_x[55:44], coord_y[67:56], zero fill [71:68].
  input  logic [71:0]                    s_axis_tdata,
  // Field: opcode[0].
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: sample_rgba[31:0], authored_mask[35:32], zero fill [39:36].
  output logic [39:0]                    m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nncs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nncs_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MAP    = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]                       state;
  logic [1:0]                       state_next;
  logic [nncs_pkg::SIDE_W-1:0]      source_side;
  logic [nncs_pkg::TGT_W-1:0]       target_side;
  logic [nncs_pkg::CHAN_W-1:0]      source_channel;
  logic [nncs_pkg::CHAN_W-1:0]      dest_channel;
  logic [nncs_pkg::SIDE_W-1:0]      side_eff;
  logic [nncs_pkg::TGT_W-1:0]       target_eff;
  logic                             in_accept;
  logic                             is_sample;
  logic                             no_source;
  logic                             zero_result;
  nncs_pkg::map_req_t               map_req;
  nncs_pkg::map_rsp_t               map_rsp;
  logic [nncs_pkg::IDX_FULL_W-1:0]  addr_full;
  logic [nncs_pkg::ADDR_W-1:0]      rd_addr;
  logic                             rd_en;
  logic                             wr_en;
  logic [nncs_pkg::PIX_W-1:0]       rd_data;
  logic [7:0]                       chan_byte;
  logic [nncs_pkg::PIX_W-1:0]       sample_rgba;
  logic [nncs_pkg::MASK_W-1:0]      authored_mask;
  logic                             out_load;
  logic                             out_valid;
  logic [39:0]                      out_data;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_side    <= '0;
      target_side    <= nncs_pkg::TGT_W'(1);
      source_channel <= '0;
      dest_channel   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nncs_pkg::CFG_SOURCE_SIDE:    source_side    <= cfg_data[nncs_pkg::SIDE_W-1:0];
        nncs_pkg::CFG_TARGET_SIDE:    target_side    <= cfg_data[nncs_pkg::TGT_W-1:0];
        nncs_pkg::CFG_SOURCE_CHANNEL: source_channel <= cfg_data[nncs_pkg::CHAN_W-1:0];
        nncs_pkg::CFG_DEST_CHANNEL:   dest_channel   <= cfg_data[nncs_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sides clamped to their supported ranges.
  assign side_eff = (source_side > nncs_pkg::SIDE_W'(nncs_pkg::MAX_SOURCE_SIDE)) ?
                    nncs_pkg::SIDE_W'(nncs_pkg::MAX_SOURCE_SIDE) : source_side;
  assign target_eff = (target_side == '0) ? nncs_pkg::TGT_W'(1) :
                      (target_side > nncs_pkg::TGT_W'(nncs_pkg::MAX_TARGET_SIDE)) ?
                      nncs_pkg::TGT_W'(nncs_pkg::MAX_TARGET_SIDE) : target_side;

  // Input request decode.
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign is_sample     = (s_axis_tuser == nncs_pkg::OP_SAMPLE);
  assign no_source     = (side_eff == '0);
  assign wr_en         = in_accept && (s_axis_tuser == nncs_pkg::OP_WRITE);

  assign map_req.start   = in_accept && is_sample && !no_source;
  assign map_req.coord_x = s_axis_tdata[55:44];
  assign map_req.coord_y = s_axis_tdata[67:56];
  assign map_req.side    = side_eff;
  assign map_req.target  = target_eff;

  nncs_coord_map u_map (
    .clk (clk),
    .rst (rst),
    .req (map_req),
    .rsp (map_rsp)
  );

  // Pixel address of the mapped source coordinate.
  assign addr_full = nncs_pkg::IDX_FULL_W'(map_rsp.sy) * nncs_pkg::IDX_FULL_W'(side_eff)
                   + nncs_pkg::IDX_FULL_W'(map_rsp.sx);

  always_ff @(posedge clk) begin
    if (map_rsp.done) begin
      rd_addr <= addr_full[nncs_pkg::ADDR_W-1:0];
    end
  end

  assign rd_en = (state == ST_READ);

  // Only one request is in flight, so a write and a read never overlap.
  nncs_pixel_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s_axis_tdata[11:0]),
    .wr_data (s_axis_tdata[43:12]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && is_sample) begin
          state_next = no_source ? ST_RESULT : ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_rsp.done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      zero_result <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        zero_result <= no_source;
      end
    end
  end

  // Channel routing.
  assign chan_byte     = rd_data[{source_channel, 3'b000} +: 8];
  assign sample_rgba   = zero_result ? '0 :
                         (nncs_pkg::PIX_W'(chan_byte) << {dest_channel, 3'b000});
  assign authored_mask = zero_result ? '0 : (nncs_pkg::MASK_W'(1) << dest_channel);

  // Output register.
  assign out_load = (state == ST_RESULT) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {4'b0000, authored_mask, sample_rgba};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // The divider finishes only while the sequencer waits for it.
  a_done_in_map: assert property (@(posedge clk) disable iff (rst)
    map_rsp.done |-> (state == ST_MAP))
    else $error("coordinate map finished outside the map state");

  // A sample with no source skips the divider and the memory.
  a_no_source: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_sample && no_source) |=> (state == ST_RESULT) && zero_result)
    else $error("sample without source did not go to the result state");

  // A pending result holds the sequencer while the output is stalled.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RESULT) && m_axis_tvalid && !m_axis_tready) |=> (state == ST_RESULT))
    else $error("result dropped while the output was stalled");

  // No new request is taken while one is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !map_req.start && !wr_en)
    else $error("request accepted while another is in flight");

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest neighbor channel sampler. A table of
// directed requests is followed by random phases that each pick new register
// settings and a new idling pattern. Every sample result is compared with a
// prediction made when the request was accepted or written in the directed table.
// ----------------------------------------------------------------------------
module tb;
  import nncs_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int DRAIN_CYCLES    = 16;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int MAX_REPORTS     = 10;
  localparam int DIRECTED_ROWS   = 28;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One sampled pixel as the block returns it.
  typedef struct packed {
    logic [PIX_W-1:0]  rgba;
    logic [MASK_W-1:0] mask;
  } sample_t;

  // One row of the directed table: a register write or a request.
  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    logic                 opcode;
    logic [ADDR_W-1:0]    idx;
    logic [PIX_W-1:0]     rgba;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    bit                   typed;
    sample_t              known;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic [71:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [39:0]       m_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Shadow of the block's registers and pixel memory.
  logic [SIDE_W-1:0] src_side;
  logic [TGT_W-1:0]  tgt_side;
  logic [CHAN_W-1:0] src_chan;
  logic [CHAN_W-1:0] dst_chan;
  logic [PIX_W-1:0]  pixel_mem [PIX_DEPTH];
  bit                pixel_written [PIX_DEPTH];

  sample_t   pending_samples [$];
  stim_row_t directed_rows [DIRECTED_ROWS];
  int        err_count;
  int        tx_gap_pct;
  int        rx_stall_pct;

  nearest_neighbor_channel_sampler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Free-running clock, 20 ns period.
  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Source side as the block uses it: capped at the memory's side.
  function automatic int unsigned eff_source_side();
    return (src_side > MAX_SOURCE_SIDE) ? MAX_SOURCE_SIDE : src_side;
  endfunction

  // Target side as the block uses it: zero reads as one, capped at the maximum.
  function automatic int unsigned eff_target_side();
    if (tgt_side == 0) return 1;
    return (tgt_side > MAX_TARGET_SIDE) ? MAX_TARGET_SIDE : tgt_side;
  endfunction

  // Nearest neighbor mapping of one axis, saturating at the last source pixel.
  function automatic int unsigned map_axis(logic [COORD_W-1:0] c, int unsigned s,
                                           int unsigned t);
    longint unsigned q;
    q = c;
    q = q * s / t;
    return (q > s - 1) ? s - 1 : int'(q);
  endfunction

  // Memory word that a sample at (cx, cy) reads, or -1 when there is no source.
  function automatic int source_index(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    int unsigned s;
    int unsigned t;
    s = eff_source_side();
    t = eff_target_side();
    if (s == 0) return -1;
    return (map_axis(cy, s, t) * s + map_axis(cx, s, t)) % PIX_DEPTH;
  endfunction

  // Expected result of a sample under the current registers and memory.
  function automatic sample_t predict_sample(logic [COORD_W-1:0] cx,
                                             logic [COORD_W-1:0] cy);
    sample_t    r;
    int         p;
    logic [7:0] v;
    r = '0;
    p = source_index(cx, cy);
    if (p >= 0) begin
      v = pixel_mem[p][8*src_chan +: 8];
      r.rgba = 32'(v) << (8 * dst_chan);
      r.mask = 4'b0001 << dst_chan;
    end
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val[CFG_DAT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t req_row(logic op, logic [ADDR_W-1:0] idx,
                                        logic [PIX_W-1:0] rgba, logic [COORD_W-1:0] cx,
                                        logic [COORD_W-1:0] cy);
    stim_row_t r;
    r = '0;
    r.opcode = op;
    r.idx    = idx;
    r.rgba   = rgba;
    r.cx     = cx;
    r.cy     = cy;
    return r;
  endfunction

  // A sample whose result is written into the table by hand.
  function automatic stim_row_t known_row(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                          logic [PIX_W-1:0] rgba, logic [MASK_W-1:0] mask);
    stim_row_t r;
    r = req_row(OP_SAMPLE, '0, '0, cx, cy);
    r.typed      = 1'b1;
    r.known.rgba = rgba;
    r.known.mask = mask;
    return r;
  endfunction

  task automatic report_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("tb: mismatch: %s", msg);
  endtask

  // Lowers the request valid at the next falling edge.
  task automatic hold_requests();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits until every sample has come back and the pipeline has emptied.
  task automatic drain();
    hold_requests();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register with the block idle and updates the shadow copy.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SOURCE_SIDE:    src_side = val[SIDE_W-1:0];
      CFG_TARGET_SIDE:    tgt_side = val[TGT_W-1:0];
      CFG_SOURCE_CHANNEL: src_chan = val[CHAN_W-1:0];
      CFG_DEST_CHANNEL:   dst_chan = val[CHAN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drives one request, optionally after a random gap, and records its effect
  // once the block has taken it.
  task automatic send_request(logic op, logic [ADDR_W-1:0] idx, logic [PIX_W-1:0] rgba,
                              logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                              bit typed, sample_t known);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, cy, cx, rgba, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_WRITE) begin
      pixel_mem[idx]     = rgba;
      pixel_written[idx] = 1'b1;
    end else begin
      pending_samples.push_back(typed ? known : predict_sample(cx, cy));
    end
  endtask

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    sample_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        report_error($sformatf("result %h with nothing pending", m_axis_tdata[35:0]));
      end else begin
        want = pending_samples.pop_front();
        if (m_axis_tdata[31:0] !== want.rgba)
          report_error($sformatf("sample_rgba expected %h got %h", want.rgba,
                                 m_axis_tdata[31:0]));
        if (m_axis_tdata[35:32] !== want.mask)
          report_error($sformatf("authored_mask expected %h got %h", want.mask,
                                 m_axis_tdata[35:32]));
      end
    end
  end

  // Receiver: ready dropped at random according to the current phase.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Hard limit on the run.
  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin : stimulus
    stim_row_t          row;
    idle_mode_t         mode;
    int                 n;
    int                 p;
    int unsigned        s_eff;
    int unsigned        t_eff;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [ADDR_W-1:0]  widx;

    rst           = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_WRITE;
    s_axis_tvalid = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SOURCE_SIDE;
    cfg_data      = '0;
    src_side      = '0;
    tgt_side      = 13'd1;
    src_chan      = '0;
    dst_chan      = '0;
    err_count     = 0;
    tx_gap_pct    = 0;
    rx_stall_pct  = 0;
    foreach (pixel_written[i]) pixel_written[i] = 1'b0;

    // Directed requests: no source after reset, one-pixel source, oversized
    // source side, target side zero and oversized, saturating coordinates.
    directed_rows = '{
      known_row(12'd0, 12'd0, 32'h0000_0000, 4'h0),
      cfg_row(CFG_SOURCE_SIDE, 1),
      req_row(OP_WRITE, 12'd0, 32'hA1B2_C3D4, 12'hFFF, 12'hFFF),
      known_row(12'd0, 12'd0, 32'h0000_00D4, 4'h1),
      known_row(12'hFFF, 12'hFFF, 32'h0000_00D4, 4'h1),
      cfg_row(CFG_SOURCE_CHANNEL, 3),
      cfg_row(CFG_DEST_CHANNEL, 3),
      known_row(12'd0, 12'd0, 32'hA100_0000, 4'h8),
      cfg_row(CFG_SOURCE_SIDE, 127),
      cfg_row(CFG_TARGET_SIDE, 0),
      req_row(OP_WRITE, 12'd63, 32'h1122_3344, 12'd0, 12'd0),
      known_row(12'd1, 12'd0, 32'h1100_0000, 4'h8),
      req_row(OP_WRITE, 12'hFFF, 32'hFFFF_FFFF, 12'd0, 12'd0),
      known_row(12'hFFF, 12'hFFF, 32'hFF00_0000, 4'h8),
      cfg_row(CFG_SOURCE_SIDE, MAX_SOURCE_SIDE),
      cfg_row(CFG_TARGET_SIDE, 8191),
      known_row(12'hFFF, 12'hFFF, 32'hFF00_0000, 4'h8),
      known_row(12'd0, 12'd0, 32'hA100_0000, 4'h8),
      cfg_row(CFG_SOURCE_CHANNEL, 1),
      cfg_row(CFG_DEST_CHANNEL, 2),
      cfg_row(CFG_TARGET_SIDE, 100),
      req_row(OP_WRITE, 12'd4064, 32'h5A6B_7C8D, 12'd7, 12'd9),
      req_row(OP_SAMPLE, 12'd4064, 32'h0F0F_0F0F, 12'd50, 12'd99),
      req_row(OP_SAMPLE, 12'd0, 32'h0, 12'd4000, 12'd0),
      cfg_row(CFG_TARGET_SIDE, MAX_TARGET_SIDE),
      req_row(OP_SAMPLE, 12'd0, 32'h0, 12'd4095, 12'd4032),
      cfg_row(CFG_SOURCE_SIDE, 0),
      known_row(12'd123, 12'd456, 32'h0000_0000, 4'h0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg)
        write_register(row.reg_idx, row.reg_val);
      else
        send_request(row.opcode, row.idx, row.rgba, row.cx, row.cy, row.typed, row.known);
    end

    // Random phases: new settings and idling pattern, then mixed requests.
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0:       write_register(CFG_SOURCE_SIDE, CFG_DAT_W'(0));
        1:       write_register(CFG_SOURCE_SIDE, CFG_DAT_W'(1));
        2:       write_register(CFG_SOURCE_SIDE, CFG_DAT_W'(MAX_SOURCE_SIDE));
        3:       write_register(CFG_SOURCE_SIDE, CFG_DAT_W'($urandom_range(65, 127)));
        4, 5, 6: write_register(CFG_SOURCE_SIDE, CFG_DAT_W'($urandom_range(2, 8)));
        default: write_register(CFG_SOURCE_SIDE, CFG_DAT_W'($urandom_range(9, 63)));
      endcase
      case ($urandom_range(0, 9))
        0:       write_register(CFG_TARGET_SIDE, CFG_DAT_W'(0));
        1:       write_register(CFG_TARGET_SIDE, CFG_DAT_W'(1));
        2:       write_register(CFG_TARGET_SIDE, CFG_DAT_W'(MAX_TARGET_SIDE));
        3:       write_register(CFG_TARGET_SIDE, CFG_DAT_W'($urandom_range(4097, 8191)));
        4, 5, 6: write_register(CFG_TARGET_SIDE, CFG_DAT_W'($urandom_range(1, 16)));
        default: write_register(CFG_TARGET_SIDE, CFG_DAT_W'($urandom_range(17, 4095)));
      endcase
      write_register(CFG_SOURCE_CHANNEL, CFG_DAT_W'($urandom_range(0, 3)));
      write_register(CFG_DEST_CHANNEL, CFG_DAT_W'($urandom_range(0, 3)));

      mode = idle_mode_t'(phase % 4);
      case (mode)
        IDLE_NONE:     begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        IDLE_SENDER:   begin tx_gap_pct = 46; rx_stall_pct = 0;  end
        IDLE_RECEIVER: begin tx_gap_pct = 0;  rx_stall_pct = 46; end
        default:       begin tx_gap_pct = 25; rx_stall_pct = 25; end
      endcase

      s_eff = eff_source_side();
      t_eff = eff_target_side();
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 35) begin
          // Pixel write, half of them aimed inside the active source square if any.
          if (s_eff > 0 && $urandom_range(0, 1) == 1)
            widx = ADDR_W'($urandom_range(0, s_eff * s_eff - 1));
          else
            widx = ADDR_W'($urandom_range(0, PIX_DEPTH - 1));
          send_request(OP_WRITE, widx, $urandom(), COORD_W'($urandom()),
                       COORD_W'($urandom()), 1'b0, '0);
          n++;
        end else begin
          // Sample, mostly inside the target; the pixel it reads is written
          // first when it has never been written.
          cx = ($urandom_range(0, 3) != 0) ? COORD_W'($urandom_range(0, t_eff - 1))
                                           : COORD_W'($urandom_range(0, 4095));
          cy = ($urandom_range(0, 3) != 0) ? COORD_W'($urandom_range(0, t_eff - 1))
                                           : COORD_W'($urandom_range(0, 4095));
          p = source_index(cx, cy);
          if (p >= 0 && !pixel_written[p]) begin
            send_request(OP_WRITE, ADDR_W'(p), $urandom(), COORD_W'($urandom()),
                         COORD_W'($urandom()), 1'b0, '0);
            n++;
          end
          send_request(OP_SAMPLE, ADDR_W'($urandom()), $urandom(), cx, cy, 1'b0, '0);
          n++;
        end
      end
    end

    // Wait for the last results, then give the verdict.
    hold_requests();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_samples.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
